// ===== rtl/kps_pkg.sv =====
// Shared constants, types and the key map of the keypad scanner.
`default_nettype none
package kps_pkg;

    localparam int ROWS   = 4;
    localparam int COLS   = 4;
    localparam int ADDR_W = 4;

    localparam logic [3:0] ROW_MASK = 4'((1 << ROWS) - 1);

    // Register indexes, paddr[3:2]
    localparam logic [1:0] REG_SETTLE  = 2'd0;
    localparam logic [1:0] REG_ROUNDS  = 2'd1;
    localparam logic [1:0] REG_GAP     = 2'd2;
    localparam logic [1:0] REG_RELEASE = 2'd3;

    typedef struct packed {
        logic [7:0] settle_ticks;
        logic [3:0] validate_rounds;
        logic [7:0] round_gap_ticks;
        logic [7:0] release_ticks;
    } t_cfg;

    typedef struct packed {
        logic [3:0] column_drive;
        logic       key_valid;
        logic [3:0] key_code;
        logic [6:0] key_char;
    } t_result;

    function automatic logic [6:0] key_char_of(input logic [1:0] row, input logic [1:0] col);
        logic [6:0] c;
        c = 7'd0;
        case ({row, col})
            4'h0: c = 7'h31;  // '1'
            4'h1: c = 7'h32;  // '2'
            4'h2: c = 7'h33;  // '3'
            4'h3: c = 7'h41;  // 'A'
            4'h4: c = 7'h34;  // '4'
            4'h5: c = 7'h35;  // '5'
            4'h6: c = 7'h36;  // '6'
            4'h7: c = 7'h42;  // 'B'
            4'h8: c = 7'h37;  // '7'
            4'h9: c = 7'h38;  // '8'
            4'hA: c = 7'h39;  // '9'
            4'hB: c = 7'h43;  // 'C'
            4'hC: c = 7'h2A;  // '*'
            4'hD: c = 7'h30;  // '0'
            4'hE: c = 7'h23;  // '#'
            default: c = 7'h44;  // 'D'
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/matrix_keypad_scanner.sv =====
// Top level of the 4x4 matrix keypad scanner.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------------
//  tick    | in        | i_in_valid / o_in_stall   | i_row_levels
//  result  | out       | o_out_valid / i_out_stall | o_column_drive, o_key_valid,
//          |           |                           | o_key_code, o_key_char
//  config  | in        | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// The state machine computes the next state and the result of a tick in a single pass.
// At the accepting edge the result is written into the output register, to be offered on
// the following cycle, or into the skid slot while that register holds an untaken result;
// one tick can be taken every cycle while o_in_stall is low.
// o_in_stall rises only when both the result register and the skid slot hold results.
// Reset is synchronous, active low; it loads register defaults 1, 4, 3, 10 and puts the
// scan at column 0. No clearing pass follows reset.
`default_nettype none
module matrix_keypad_scanner (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    // tick channel
    input  wire                       i_in_valid,
    output logic                      o_in_stall,
    input  wire [3:0]                 i_row_levels,
    // result channel
    output logic                      o_out_valid,
    input  wire                       i_out_stall,
    output logic [3:0]                o_column_drive,
    output logic                      o_key_valid,
    output logic [3:0]                o_key_code,
    output logic [6:0]                o_key_char,
    // configuration port
    input  wire                       psel,
    input  wire                       penable,
    input  wire                       pwrite,
    input  wire [kps_pkg::ADDR_W-1:0] paddr,
    input  wire [31:0]                pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import kps_pkg::*;

    t_cfg    cfg;
    t_result fsm_res;
    t_result out_res;
    logic    acc;
    logic    full;

    // accept a tick whenever the skid slot is free
    assign o_in_stall = full;
    assign acc        = i_in_valid && !full;

    kps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // advance scan / validate / release sequencing on each accepted tick
    kps_fsm u_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (acc),
        .i_row_levels (i_row_levels),
        .i_cfg        (cfg),
        .o_res        (fsm_res)
    );

    // hold results until the consumer takes them
    kps_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_res   (fsm_res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_res   (out_res),
        .o_full  (full)
    );

    assign o_column_drive = out_res.column_drive;
    assign o_key_valid    = out_res.key_valid;
    assign o_key_code     = out_res.key_code;
    assign o_key_char     = out_res.key_char;

endmodule
`default_nettype wire

// ===== rtl/kps_regs.sv =====
// Configuration register file behind the APB-style port.
`default_nettype none
module kps_regs (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       psel,
    input  wire                       penable,
    input  wire                       pwrite,
    input  wire [kps_pkg::ADDR_W-1:0] paddr,
    input  wire [31:0]                pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output kps_pkg::t_cfg             o_cfg
);
    import kps_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ticks    <= 8'd1;
            r_cfg.validate_rounds <= 4'd4;
            r_cfg.round_gap_ticks <= 8'd3;
            r_cfg.release_ticks   <= 8'd10;
        end else if (wr_en) begin
            unique case (idx)
                REG_SETTLE:  r_cfg.settle_ticks    <= pwdata[7:0];
                REG_ROUNDS:  r_cfg.validate_rounds <= pwdata[3:0];
                REG_GAP:     r_cfg.round_gap_ticks <= pwdata[7:0];
                REG_RELEASE: r_cfg.release_ticks   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_SETTLE:  prdata = {24'd0, r_cfg.settle_ticks};
            REG_ROUNDS:  prdata = {28'd0, r_cfg.validate_rounds};
            REG_GAP:     prdata = {24'd0, r_cfg.round_gap_ticks};
            REG_RELEASE: prdata = {24'd0, r_cfg.release_ticks};
            default:     prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/kps_fsm.sv =====
// Scan, validation and release state machine; one tick per accepted transaction.
`default_nettype none
module kps_fsm (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_acc,
    input  wire [3:0]        i_row_levels,
    input  kps_pkg::t_cfg    i_cfg,
    output kps_pkg::t_result o_res
);
    import kps_pkg::*;

    localparam logic [2:0] PH_SCAN   = 3'd0;
    localparam logic [2:0] PH_VIDLE  = 3'd1;
    localparam logic [2:0] PH_VDRIVE = 3'd2;
    localparam logic [2:0] PH_GAP    = 3'd3;
    localparam logic [2:0] PH_RDRIVE = 3'd4;
    localparam logic [2:0] PH_RDELAY = 3'd5;

    logic [2:0] r_phase, n_phase;
    logic [1:0] r_scan_col, n_scan_col;
    logic [7:0] r_wait, n_wait;
    logic       r_hit_seen, n_hit_seen;
    logic [3:0] r_round, n_round;
    logic [1:0] r_held_row, n_held_row;
    logic [1:0] r_held_col, n_held_col;
    logic       r_key_held, n_key_held;

    logic [3:0] pr;
    logic [2:0] n_hits;
    logic [1:0] low_row;
    logic [7:0] wait_inc;
    logic [7:0] settle_lim;
    logic [3:0] round_need;
    logic [3:0] round_inc;
    logic       settled;
    logic       last_col;
    logic       rst_scan;
    logic       do_end;
    logic       report;
    logic [3:0] drive;

    assign pr         = ~i_row_levels & ROW_MASK;
    assign n_hits     = 3'($countones(pr));
    assign wait_inc   = r_wait + 8'd1;
    assign settle_lim = (i_cfg.settle_ticks == 8'd0) ? 8'd1 : i_cfg.settle_ticks;
    assign round_need = (i_cfg.validate_rounds == 4'd0) ? 4'd1 : i_cfg.validate_rounds;
    assign round_inc  = r_round + 4'd1;
    assign settled    = wait_inc >= settle_lim;
    assign last_col   = ({1'b0, r_scan_col} + 3'd1) >= 3'(COLS);

    always_comb begin
        low_row = 2'd0;
        for (int i = ROWS - 1; i >= 0; i--) begin
            if (pr[i]) low_row = 2'(i);
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_scan_col = r_scan_col;
        n_wait     = r_wait;
        n_hit_seen = r_hit_seen;
        n_round    = r_round;
        n_held_row = r_held_row;
        n_held_col = r_held_col;
        n_key_held = r_key_held;
        rst_scan   = 1'b0;
        do_end     = 1'b0;
        report     = 1'b0;

        unique case (r_phase)
            PH_SCAN: begin
                n_wait = wait_inc;
                if (settled) begin
                    if (n_hits > 3'd1 || (r_hit_seen && n_hits == 3'd1)) begin
                        rst_scan = 1'b1;
                    end else begin
                        if (n_hits == 3'd1) begin
                            n_held_row = low_row;
                            n_held_col = r_scan_col;
                            n_hit_seen = 1'b1;
                        end
                        n_wait = 8'd0;
                        if (last_col) begin
                            if (n_hit_seen) begin
                                n_phase = PH_VIDLE;
                                n_round = 4'd0;
                            end else begin
                                rst_scan = 1'b1;
                            end
                        end else begin
                            n_scan_col = r_scan_col + 2'd1;
                        end
                    end
                end
            end
            PH_VIDLE: begin
                n_wait = wait_inc;
                if (settled) begin
                    if (pr != 4'd0) begin
                        rst_scan = 1'b1;
                    end else begin
                        n_phase = PH_VDRIVE;
                        n_wait  = 8'd0;
                    end
                end
            end
            PH_VDRIVE: begin
                n_wait = wait_inc;
                if (settled) begin
                    if (pr != (4'd1 << r_held_row)) begin
                        rst_scan = 1'b1;
                    end else if (i_cfg.round_gap_ticks == 8'd0) begin
                        do_end = 1'b1;
                    end else begin
                        n_phase = PH_GAP;
                        n_wait  = 8'd0;
                    end
                end
            end
            PH_GAP: begin
                n_wait = wait_inc;
                if (wait_inc >= i_cfg.round_gap_ticks) do_end = 1'b1;
            end
            PH_RDRIVE: begin
                n_wait = wait_inc;
                if (settled) begin
                    n_wait = 8'd0;
                    if (!pr[r_held_row]) begin
                        if (i_cfg.release_ticks == 8'd0) begin
                            n_key_held = 1'b0;
                            rst_scan   = 1'b1;
                        end else begin
                            n_phase = PH_RDELAY;
                        end
                    end
                end
            end
            PH_RDELAY: begin
                n_wait = wait_inc;
                if (wait_inc >= i_cfg.release_ticks) begin
                    if (!pr[r_held_row]) begin
                        n_key_held = 1'b0;
                        rst_scan   = 1'b1;
                    end else begin
                        n_phase = PH_RDRIVE;
                        n_wait  = 8'd0;
                    end
                end
            end
            default: rst_scan = 1'b1;
        endcase

        // close a validation round: report or go for the next one
        if (do_end) begin
            n_round = round_inc;
            n_wait  = 8'd0;
            if (round_inc >= round_need) begin
                n_key_held = 1'b1;
                n_phase    = PH_RDRIVE;
                report     = 1'b1;
            end else begin
                n_phase = PH_VIDLE;
            end
        end

        if (rst_scan) begin
            n_phase    = PH_SCAN;
            n_scan_col = 2'd0;
            n_wait     = 8'd0;
            n_hit_seen = 1'b0;
            n_round    = 4'd0;
        end
    end

    always_comb begin
        case (n_phase) inside
            PH_SCAN:                         drive = ~(4'd1 << n_scan_col);
            PH_VDRIVE, PH_RDRIVE, PH_RDELAY: drive = ~(4'd1 << n_held_col);
            default:                         drive = 4'hF;
        endcase
    end

    always_comb begin
        o_res.column_drive = drive;
        o_res.key_valid    = report;
        o_res.key_code     = report ? {n_held_row, n_held_col} : 4'd0;
        o_res.key_char     = report ? key_char_of(n_held_row, n_held_col) : 7'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SCAN;
            r_scan_col <= 2'd0;
            r_wait     <= 8'd0;
            r_hit_seen <= 1'b0;
            r_round    <= 4'd0;
            r_held_row <= 2'd0;
            r_held_col <= 2'd0;
            r_key_held <= 1'b0;
        end else if (i_acc) begin
            r_phase    <= n_phase;
            r_scan_col <= n_scan_col;
            r_wait     <= n_wait;
            r_hit_seen <= n_hit_seen;
            r_round    <= n_round;
            r_held_row <= n_held_row;
            r_held_col <= n_held_col;
            r_key_held <= n_key_held;
        end
    end

    a_held_matches_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_held == (r_phase == PH_RDRIVE || r_phase == PH_RDELAY))
        else $error("key held flag out of step with phase");

    a_scan_no_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SCAN) |-> (r_round == 4'd0))
        else $error("round count left over during scan");

    a_report_holds_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && report) |=> (r_key_held && r_phase == PH_RDRIVE))
        else $error("reported key not held");

endmodule
`default_nettype wire

// ===== rtl/kps_outq.sv =====
// Two-entry output buffer: result register plus skid slot.
`default_nettype none
module kps_outq (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_acc,
    input  kps_pkg::t_result i_res,
    input  wire              i_stall,
    output logic             o_valid,
    output kps_pkg::t_result o_res,
    output logic             o_full
);
    import kps_pkg::*;

    logic    r_out_vld;
    logic    r_skid_vld;
    t_result r_out;
    t_result r_skid;
    logic    take;

    assign take    = r_out_vld && !i_stall;
    assign o_valid = r_out_vld;
    assign o_res   = r_out;
    assign o_full  = r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (i_acc) begin
            if (!r_out_vld || take) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (take) begin
            if (r_skid_vld) begin
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            if (!r_out_vld || take) r_out  <= i_res;
            else                    r_skid <= i_res;
        end else if (take && r_skid_vld) begin
            r_out <= r_skid;
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid slot full with result register empty");

endmodule
`default_nettype wire
